// File: rtl/core/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared definitions for the voxel ray caster
// Field widths, fixed-point constants, word layouts and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // default grid side
  localparam int GRID_SIDE_DEF = 32;

  // fixed point
  localparam int FRAC     = 16;
  localparam int ONE_Q    = 1 << FRAC;
  localparam int EPS      = (ONE_Q + 5000) / 10000;

  // field widths
  localparam int IDX_W    = 15;
  localparam int START_W  = 21;
  localparam int DIR_W    = 18;
  localparam int MAG_W    = 18;
  localparam int LEN_W    = 23;
  localparam int PT_W     = 24;
  localparam int OCELL_W  = 8;
  localparam int CELL_W   = 10;

  // internal widths
  localparam int SUM_W    = 36;
  localparam int RAD_W    = 60;
  localparam int ROOT_W   = 30;
  localparam int REM_W    = 32;
  localparam int SIDE_W   = 39;
  localparam int QUOT_W   = 35;
  localparam int ACC_W    = 42;
  localparam int PSUM_W   = 26;

  // iterative step counts
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DDIV_STEPS = QUOT_W;
  localparam int ODIV_STEPS = PT_W;

  localparam logic [SIDE_W-1:0] SAT         = SIDE_W'(1) << 38;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = LEN_W'(524288);
  localparam logic [LEN_W-1:0]  LEN_CLAMP   = {LEN_W{1'b1}};

  // command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // stream word widths
  localparam int IN_W  = 136;
  localparam int OUT_W = 168;

  // commands from controller to datapath
  typedef struct packed {
    logic       cast_load;
    logic       vox_write;
    logic       sq_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_off;
    logic       div_step;
    logic       delta_store;
    logic       off_store;
    logic       side_lo;
    logic       side_hi;
    logic       walk_rd;
    logic       walk_step;
    logic       hit_set;
    logic       out_load;
    logic [1:0] axis;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mem_busy;
    logic dir_zero;
    logic len_done;
    logic solid;
  } dp_status_t;

endpackage

// File: rtl/core/vrt_occ_mem.sv
// ----------------------------------------------------------------------------
// vrt_occ_mem: occupancy bitmap storage
// Rows of 32 voxel bits, one bit write port, one registered row read port.
// A sweep after reset clears one row per cycle while busy_o is high.
// ----------------------------------------------------------------------------
module vrt_occ_mem #(
  parameter int ROWS  = 1024,
  parameter int ROW_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  logic [4:0]       wr_bit_i,
  input  logic             wr_val_i,
  input  logic             rd_en_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output logic [31:0]      rd_data_o,
  output logic             busy_o
);

  logic [31:0]      mem [ROWS];
  logic [31:0]      rd_data_q;
  logic [ROW_W-1:0] clr_q, clr_d;
  logic             busy_q, busy_d;

  // clearing sweep control
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + ROW_W'(1);
      if (clr_q == ROW_W'(ROWS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // array access
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_row_i][wr_bit_i] <= wr_val_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// File: rtl/core/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath: arithmetic and walk state of the ray caster
// Shared 18x24 multiplier, bit-pair square root, restoring divider, DDA side
// distances, occupancy map and the output word register.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int GRID_SIDE = vrt_pkg::GRID_SIDE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vrt_pkg::dp_cmd_t                cmd_i,
  output vrt_pkg::dp_status_t             status_o,
  input  logic [vrt_pkg::IN_W-1:0]        in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [vrt_pkg::LEN_W-1:0]       cfg_data_i,
  output logic [vrt_pkg::OUT_W-1:0]       out_data_o
);

  localparam int MapFull   = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int MAP_CELLS = (MapFull < 32768) ? MapFull : 32768;
  localparam int ROWS      = (MAP_CELLS + 31) / 32;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W    = $clog2(MapFull) + 1;

  localparam int CW = vrt_pkg::CELL_W;
  localparam int SW = vrt_pkg::SIDE_W;

  // input word fields
  logic [vrt_pkg::IDX_W-1:0]          in_idx;
  logic                               in_solid;
  logic [vrt_pkg::START_W-1:0]        in_s   [3];
  logic signed [vrt_pkg::DIR_W-1:0]   in_d   [3];

  assign in_idx   = in_data_i[14:0];
  assign in_solid = in_data_i[15];
  assign in_s[0]  = in_data_i[36:16];
  assign in_s[1]  = in_data_i[57:37];
  assign in_s[2]  = in_data_i[78:58];
  assign in_d[0]  = in_data_i[96:79];
  assign in_d[1]  = in_data_i[114:97];
  assign in_d[2]  = in_data_i[132:115];

  // registers
  logic [vrt_pkg::LEN_W-1:0]   max_len_q;
  logic [vrt_pkg::START_W-1:0] s_q     [3];
  logic [vrt_pkg::MAG_W-1:0]   mag_q   [3];
  logic                        neg_q   [3];
  logic signed [CW-1:0]        cell_q  [3];
  logic signed [CW-1:0]        prev_q  [3];
  logic [SW-1:0]               delta_q [3];
  logic [SW-1:0]               side_q  [3];
  logic [vrt_pkg::PT_W-1:0]    off_q   [3];
  logic [SW-1:0]               len_q;
  logic                        hit_q;
  logic [vrt_pkg::SUM_W-1:0]   sum_q;
  logic [vrt_pkg::RAD_W-1:0]   rad_q;
  logic [vrt_pkg::REM_W-1:0]   rem_q;
  logic [vrt_pkg::ROOT_W-1:0]  root_q;
  logic [vrt_pkg::ROOT_W-1:0]  dr_q;
  logic [vrt_pkg::ROOT_W-1:0]  dvs_q;
  logic [vrt_pkg::QUOT_W-1:0]  dsh_q;
  logic [vrt_pkg::QUOT_W-1:0]  quot_q;
  logic [vrt_pkg::ACC_W-1:0]   acc_q;
  logic                        rd_ok_q;
  logic [4:0]                  rd_bit_q;
  logic [vrt_pkg::OUT_W-1:0]   out_q;

  logic [1:0] ax;
  assign ax = cmd_i.axis;

  // clamped lengths
  logic [vrt_pkg::LEN_W-1:0] hl, bl;
  assign hl = (|len_q[SW-1:vrt_pkg::LEN_W]) ? vrt_pkg::LEN_CLAMP : len_q[vrt_pkg::LEN_W-1:0];
  assign bl = (hl > vrt_pkg::LEN_W'(vrt_pkg::EPS)) ? hl - vrt_pkg::LEN_W'(vrt_pkg::EPS) : '0;

  // shared multiplier
  logic [16:0]               weight;
  logic [15:0]               fr;
  logic [17:0]               mul_a;
  logic [23:0]               mul_b;
  logic [vrt_pkg::ACC_W-1:0] mul_p;

  assign fr     = s_q[ax][15:0];
  assign weight = neg_q[ax] ? {1'b0, fr} : 17'(vrt_pkg::ONE_Q) - {1'b0, fr};

  always_comb begin
    mul_a = mag_q[ax];
    mul_b = 24'(mag_q[ax]);
    if (cmd_i.side_lo) begin
      mul_a = {1'b0, weight};
      mul_b = delta_q[ax][23:0];
    end else if (cmd_i.side_hi) begin
      mul_a = {1'b0, weight};
      mul_b = {9'b0, delta_q[ax][SW-1:24]};
    end else if (cmd_i.div_init) begin
      mul_b = {1'b0, hl};
    end
  end
  assign mul_p = vrt_pkg::ACC_W'(mul_a) * vrt_pkg::ACC_W'(mul_b);

  // side distance from two partial products
  logic [56:0]   side_tot;
  logic [40:0]   side_shr;
  logic [SW-1:0] side_init;
  assign side_tot  = 57'(acc_q) + (57'(mul_p) << 24);
  assign side_shr  = side_tot[56:16];
  assign side_init = (side_shr > 41'(vrt_pkg::SAT)) ? vrt_pkg::SAT : side_shr[SW-1:0];

  // square root step
  logic [33:0] sq_rem, sq_trial;
  logic        sq_ge;
  assign sq_rem   = {rem_q, rad_q[vrt_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {2'b0, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  // divider step and offset dividend
  logic [30:0] dv_t;
  logic        dv_ge;
  logic [52:0] off_dvd;
  assign dv_t    = {dr_q, dsh_q[vrt_pkg::QUOT_W-1]};
  assign dv_ge   = dv_t >= {1'b0, dvs_q};
  assign off_dvd = {mul_p[40:0], 12'b0} + 53'(root_q >> 1);

  // axis choice, z then y preferred on ties
  logic [1:0]    step_ax;
  logic [SW:0]   side_sum;
  always_comb begin
    if (side_q[0] < side_q[1] && side_q[0] < side_q[2]) begin
      step_ax = 2'd0;
    end else if (side_q[1] < side_q[2]) begin
      step_ax = 2'd1;
    end else begin
      step_ax = 2'd2;
    end
  end
  assign side_sum = {1'b0, side_q[step_ax]} + {1'b0, delta_q[step_ax]};

  // map address of the current cell
  logic              in_grid;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;
  always_comb begin
    in_grid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (cell_q[i][CW-1] || (cell_q[i] >= $signed(CW'(GRID_SIDE)))) begin
        in_grid = 1'b0;
      end
    end
  end
  assign rd_addr = ADDR_W'(cell_q[0][CW-2:0])
                 + ADDR_W'(GRID_SIDE) * ADDR_W'(cell_q[1][CW-2:0])
                 + ADDR_W'(GRID_SIDE * GRID_SIDE) * ADDR_W'(cell_q[2][CW-2:0]);
  assign rd_ok   = in_grid && (rd_addr < ADDR_W'(MAP_CELLS));

  // occupancy map
  logic        mem_busy;
  logic [31:0] rd_data;
  logic        wr_en;
  assign wr_en = cmd_i.vox_write && (32'(in_idx) < 32'(MAP_CELLS));

  vrt_occ_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_row_i  (ROW_W'(in_idx >> 5)),
    .wr_bit_i  (in_idx[4:0]),
    .wr_val_i  (in_solid),
    .rd_en_i   (cmd_i.walk_rd),
    .rd_row_i  (ROW_W'(rd_addr >> 5)),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  // final points
  logic [vrt_pkg::PT_W-1:0] pt [3];
  always_comb begin
    logic signed [vrt_pkg::PSUM_W-1:0] p;
    for (int i = 0; i < 3; i++) begin
      p = $signed(vrt_pkg::PSUM_W'(s_q[i]));
      if (sum_q != '0) begin
        if (neg_q[i]) p = p - $signed(vrt_pkg::PSUM_W'(off_q[i]));
        else          p = p + $signed(vrt_pkg::PSUM_W'(off_q[i]));
      end
      if (p > $signed(vrt_pkg::PSUM_W'(8388607))) begin
        pt[i] = 24'h7FFFFF;
      end else if (p < -$signed(vrt_pkg::PSUM_W'(8388608))) begin
        pt[i] = 24'h800000;
      end else begin
        pt[i] = p[vrt_pkg::PT_W-1:0];
      end
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= vrt_pkg::MAX_LEN_RST;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // walk control flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.cast_load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.hit_set) begin
      hit_q <= 1'b1;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_load) begin
      for (int i = 0; i < 3; i++) begin
        s_q[i]    <= in_s[i];
        neg_q[i]  <= in_d[i][vrt_pkg::DIR_W-1];
        mag_q[i]  <= in_d[i][vrt_pkg::DIR_W-1] ? vrt_pkg::MAG_W'(-in_d[i])
                                               : vrt_pkg::MAG_W'(in_d[i]);
        cell_q[i] <= CW'(in_s[i][vrt_pkg::START_W-1:vrt_pkg::FRAC]);
        prev_q[i] <= CW'(in_s[i][vrt_pkg::START_W-1:vrt_pkg::FRAC]);
      end
      sum_q <= '0;
      len_q <= '0;
    end
    if (cmd_i.sq_step) begin
      sum_q <= sum_q + vrt_pkg::SUM_W'(mul_p);
    end
    // square root
    if (cmd_i.sqrt_init) begin
      rad_q  <= {sum_q, 24'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= sq_ge ? vrt_pkg::REM_W'(sq_rem - sq_trial) : sq_rem[vrt_pkg::REM_W-1:0];
      root_q <= {root_q[vrt_pkg::ROOT_W-2:0], sq_ge};
    end
    // divider
    if (cmd_i.div_init) begin
      quot_q <= '0;
      if (cmd_i.div_off) begin
        dr_q  <= {1'b0, off_dvd[52:24]};
        dsh_q <= {off_dvd[23:0], 11'b0};
        dvs_q <= root_q;
      end else begin
        dr_q  <= '0;
        dsh_q <= {1'b0, root_q, 4'b0};
        dvs_q <= vrt_pkg::ROOT_W'(mag_q[ax]);
      end
    end else if (cmd_i.div_step) begin
      dr_q   <= dv_ge ? vrt_pkg::ROOT_W'(dv_t - {1'b0, dvs_q}) : dv_t[vrt_pkg::ROOT_W-1:0];
      dsh_q  <= dsh_q << 1;
      quot_q <= {quot_q[vrt_pkg::QUOT_W-2:0], dv_ge};
    end
    if (cmd_i.delta_store) begin
      delta_q[ax] <= (mag_q[ax] == '0) ? vrt_pkg::SAT : SW'(quot_q);
    end
    if (cmd_i.off_store) begin
      off_q[ax] <= quot_q[vrt_pkg::PT_W-1:0];
    end
    // initial side distances
    if (cmd_i.side_lo) begin
      acc_q <= mul_p;
    end
    if (cmd_i.side_hi) begin
      side_q[ax] <= side_init;
    end
    // DDA walk
    if (cmd_i.walk_rd) begin
      rd_ok_q  <= rd_ok;
      rd_bit_q <= rd_addr[4:0];
    end
    if (cmd_i.walk_step) begin
      prev_q <= cell_q;
      cell_q[step_ax] <= neg_q[step_ax] ? cell_q[step_ax] - CW'(1) : cell_q[step_ax] + CW'(1);
      len_q <= side_q[step_ax];
      side_q[step_ax] <= (side_sum > {1'b0, vrt_pkg::SAT}) ? vrt_pkg::SAT : side_sum[SW-1:0];
    end
    // output word
    if (cmd_i.out_load) begin
      out_q <= {1'b0, pt[2], pt[1], pt[0], bl, hl,
                prev_q[2][7:0], prev_q[1][7:0], prev_q[0][7:0],
                cell_q[2][7:0], cell_q[1][7:0], cell_q[0][7:0], hit_q};
    end
  end

  assign status_o.mem_busy = mem_busy;
  assign status_o.dir_zero = (sum_q == '0);
  assign status_o.len_done = (len_q >= SW'(max_len_q));
  assign status_o.solid    = rd_ok_q & rd_data[rd_bit_q];
  assign out_data_o        = out_q;

endmodule

// File: rtl/core/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl: sequencer of the ray caster
// Steps the datapath through set-up, DDA walk and point computation and
// owns both stream handshakes.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tuser_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  vrt_pkg::dp_status_t status_i,
  output vrt_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_SQI    = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_DINIT  = 4'd5;
  localparam logic [3:0] S_DDIV   = 4'd6;
  localparam logic [3:0] S_DSTORE = 4'd7;
  localparam logic [3:0] S_SLO    = 4'd8;
  localparam logic [3:0] S_SHI    = 4'd9;
  localparam logic [3:0] S_WRD    = 4'd10;
  localparam logic [3:0] S_WCHK   = 4'd11;
  localparam logic [3:0] S_OINIT  = 4'd12;
  localparam logic [3:0] S_ODIV   = 4'd13;
  localparam logic [3:0] S_OSTORE = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  localparam logic [5:0] SQRT_LAST = 6'(vrt_pkg::SQRT_STEPS - 1);
  localparam logic [5:0] DDIV_LAST = 6'(vrt_pkg::DDIV_STEPS - 1);
  localparam logic [5:0] ODIV_LAST = 6'(vrt_pkg::ODIV_STEPS - 1);
  localparam logic [1:0] AX_LAST   = 2'd2;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;
  logic       mval_q, mval_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ax_d       = ax_q;
    cmd_o      = '0;
    cmd_o.axis = ax_q;
    s_tready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (!status_i.mem_busy) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (s_tuser_i == vrt_pkg::CMD_CAST) begin
            cmd_o.cast_load = 1'b1;
            ax_d            = '0;
            state_d         = S_SQ;
          end else begin
            cmd_o.vox_write = 1'b1;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (ax_q == AX_LAST) begin
          state_d = S_SQI;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == SQRT_LAST) begin
          ax_d    = '0;
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DDIV;
      end
      S_DDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == DDIV_LAST) state_d = S_DSTORE;
      end
      S_DSTORE: begin
        cmd_o.delta_store = 1'b1;
        if (ax_q == AX_LAST) begin
          ax_d    = '0;
          state_d = S_SLO;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_DINIT;
        end
      end
      S_SLO: begin
        cmd_o.side_lo = 1'b1;
        state_d       = S_SHI;
      end
      S_SHI: begin
        cmd_o.side_hi = 1'b1;
        if (ax_q == AX_LAST) begin
          ax_d    = '0;
          state_d = S_WRD;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_SLO;
        end
      end
      S_WRD: begin
        if (status_i.len_done) begin
          ax_d    = '0;
          state_d = S_OINIT;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WCHK;
        end
      end
      S_WCHK: begin
        if (status_i.solid) begin
          cmd_o.hit_set = 1'b1;
          ax_d          = '0;
          state_d       = S_OINIT;
        end else if (status_i.dir_zero) begin
          ax_d    = '0;
          state_d = S_OINIT;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_WRD;
        end
      end
      S_OINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_off  = 1'b1;
        cnt_d          = '0;
        state_d        = S_ODIV;
      end
      S_ODIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == ODIV_LAST) state_d = S_OSTORE;
      end
      S_OSTORE: begin
        cmd_o.off_store = 1'b1;
        if (ax_q == AX_LAST) begin
          state_d = S_OUT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_OINIT;
        end
      end
      S_OUT: begin
        // wait for the output register to be free
        if (!mval_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    mval_d = mval_q;
    if (cmd_o.out_load) begin
      mval_d = 1'b1;
    end else if (m_tready_i) begin
      mval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      ax_q    <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
      mval_q  <= mval_d;
    end
  end

  assign m_tvalid_o = mval_q;

endmodule

// File: rtl/core/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top: 3D DDA ray caster over a voxel occupancy bitmap
//
//  port group   dir  word carried
//  s_axis       in   write a voxel bit or cast a ray (kind in tuser)
//  m_axis       out  one result word per cast
//  cfg          in   max walk length
//
//  A voxel write is taken in the idle state and leaves s_axis_tready high. A cast
//  runs set-up and point computation (squares, root, three divisions for the axis
//  deltas, side distances, three divisions for the hit point, output) plus a
//  read state and a check state per visited cell, set by the single registered
//  read port of the bitmap; s_axis_tready returns in the cycle after the result
//  word is loaded.
//  After reset a clearing sweep of ceil(min(GRID_SIDE^3, 32768) / 32) bitmap rows
//  (1024 at the default size) runs before s_axis_tready rises.
//  A finished word waits in the output register while the next item is taken;
//  a cast that ends while that word is still held stalls until it leaves.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top #(
  parameter int GRID_SIDE = vrt_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // voxel_index, voxel_solid, start_x, start_y, start_z, dir_x, dir_y, dir_z
  input  logic [vrt_pkg::IN_W-1:0]    s_axis_tdata,
  // cmd
  input  logic                        s_axis_tuser,
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // collided, hit_cell_x/y/z, prev_cell_x/y/z, hit_length, before_length,
  // point_x, point_y, point_z
  output logic [vrt_pkg::OUT_W-1:0]   m_axis_tdata,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [vrt_pkg::LEN_W-1:0]   cfg_data_i
);

  vrt_pkg::dp_cmd_t    cmd;
  vrt_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  vrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vrt_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for voxel_ray_traversal_top
// Drives voxel writes and ray casts on the input stream and register writes on
// the cfg channel. A behavioral DDA tracer keeps its own occupancy map and walk
// limit and predicts casts that lack a typed-in result, checked field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    NCELLS      = 32768;
  localparam int    RAND_ITEMS  = 2000;
  localparam int    DRAIN_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint SAT_L      = longint'(1) << 38;

  // one input word
  typedef struct {
    logic              cmd;
    logic [14:0]       idx;
    logic              solid;
    logic [20:0]       sx, sy, sz;
    logic signed [17:0] dx, dy, dz;
  } ray_item_t;

  // one result word, highest field first
  typedef struct packed {
    logic [23:0] ptz, pty, ptx;
    logic [22:0] before_len;
    logic [22:0] hit_len;
    logic [7:0]  pz, py, px;
    logic [7:0]  hz, hy, hx;
    logic        collided;
  } ray_res_t;

  // directed row: a cfg write or an item, with an optional typed-in result
  typedef struct {
    bit          is_cfg;
    logic [22:0] cfg_val;
    ray_item_t   item;
    bit          lit;
    logic        lit_hit;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [vrt_pkg::IN_W-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [vrt_pkg::LEN_W-1:0] cfg_data = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready_o;
  logic [vrt_pkg::OUT_W-1:0] m_axis_tdata;

  bit          occ_map [NCELLS];
  logic [22:0] walk_limit;
  ray_res_t    pending_rays[$];
  int          mismatches = 0;
  longint      cycles = 0;
  int          send_idle_pct = 20;
  int          recv_stall_pct = 20;

  always #4 clk_i = ~clk_i;

  voxel_ray_traversal_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready,
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid, .m_axis_tready(m_ready), .m_axis_tdata,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_data_i(cfg_data)
  );

  // integer square root, bit by bit
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit cell_solid(input int c[3]);
    for (int i = 0; i < 3; i++)
      if (c[i] < 0 || c[i] >= 32) return 1'b0;
    return occ_map[c[0] + 32 * c[1] + 1024 * c[2]];
  endfunction

  // DDA walk with the current map and walk limit
  function automatic ray_res_t trace_ray(input ray_item_t it);
    longint unsigned st[3], delta[3], side[3], mag[3], fr, lq, sum, len, hl, bl, off;
    longint dv[3], p;
    int vox[3], prev[3], ax;
    bit hit, zero;
    ray_res_t r;
    st[0] = it.sx; st[1] = it.sy; st[2] = it.sz;
    dv[0] = it.dx; dv[1] = it.dy; dv[2] = it.dz;
    sum = 0; lq = 0; len = 0; hit = 0;
    for (int i = 0; i < 3; i++) begin
      vox[i] = int'(st[i] >> 16);
      prev[i] = vox[i];
      mag[i] = dv[i] < 0 ? -dv[i] : dv[i];
      sum += mag[i] * mag[i];
    end
    zero = (sum == 0);
    if (!zero) lq = root64(sum << 24);
    for (int i = 0; i < 3; i++) begin
      fr = st[i] & 16'hFFFF;
      if (mag[i] == 0) delta[i] = SAT_L;
      else begin
        delta[i] = (lq << 16) / (mag[i] << 12);
        if (delta[i] > SAT_L) delta[i] = SAT_L;
      end
      side[i] = ((dv[i] < 0 ? fr : 65536 - fr) * delta[i]) >> 16;
      if (side[i] > SAT_L) side[i] = SAT_L;
    end
    while (len < walk_limit) begin
      if (cell_solid(vox)) begin
        hit = 1;
        break;
      end
      if (zero) break;
      prev = vox;
      if (side[0] < side[1] && side[0] < side[2]) ax = 0;
      else if (side[1] < side[2]) ax = 1;
      else ax = 2;
      vox[ax] += (dv[ax] < 0) ? -1 : 1;
      len = side[ax];
      side[ax] += delta[ax];
      if (side[ax] > SAT_L) side[ax] = SAT_L;
    end
    hl = len > 64'h7FFFFF ? 64'h7FFFFF : len;
    bl = hl > vrt_pkg::EPS ? hl - vrt_pkg::EPS : 0;
    r.collided = hit;
    r.hx = vox[0][7:0]; r.hy = vox[1][7:0]; r.hz = vox[2][7:0];
    r.px = prev[0][7:0]; r.py = prev[1][7:0]; r.pz = prev[2][7:0];
    r.hit_len = hl[22:0];
    r.before_len = bl[22:0];
    for (int i = 0; i < 3; i++) begin
      p = longint'(st[i]);
      if (!zero && lq != 0) begin
        off = (((mag[i] * hl) << 12) + lq / 2) / lq;
        p = dv[i] < 0 ? p - longint'(off) : p + longint'(off);
      end
      if (p > 8388607) p = 8388607;
      if (p < -8388608) p = -8388608;
      if (i == 0) r.ptx = p[23:0];
      else if (i == 1) r.pty = p[23:0];
      else r.ptz = p[23:0];
    end
    return r;
  endfunction

  // result for a walk that never leaves the start cell
  function automatic ray_res_t start_cell_res(input ray_item_t it, input logic hit);
    ray_res_t r;
    r.collided = hit;
    r.hx = 8'(it.sx[20:16]); r.hy = 8'(it.sy[20:16]); r.hz = 8'(it.sz[20:16]);
    r.px = r.hx; r.py = r.hy; r.pz = r.hz;
    r.hit_len = '0; r.before_len = '0;
    r.ptx = {3'b0, it.sx}; r.pty = {3'b0, it.sy}; r.ptz = {3'b0, it.sz};
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: check each accepted word, stall at random
  always @(posedge clk_i) begin
    ray_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = ray_res_t'(m_axis_tdata[166:0]);
      if (pending_rays.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = pending_rays.pop_front();
        if (got.collided != want.collided) report("collided", got.collided, want.collided);
        if (got.hx != want.hx) report("hit_cell_x", got.hx, want.hx);
        if (got.hy != want.hy) report("hit_cell_y", got.hy, want.hy);
        if (got.hz != want.hz) report("hit_cell_z", got.hz, want.hz);
        if (got.px != want.px) report("prev_cell_x", got.px, want.px);
        if (got.py != want.py) report("prev_cell_y", got.py, want.py);
        if (got.pz != want.pz) report("prev_cell_z", got.pz, want.pz);
        if (got.hit_len != want.hit_len) report("hit_length", got.hit_len, want.hit_len);
        if (got.before_len != want.before_len)
          report("before_length", got.before_len, want.before_len);
        if (got.ptx != want.ptx) report("point_x", got.ptx, want.ptx);
        if (got.pty != want.pty) report("point_y", got.pty, want.pty);
        if (got.ptz != want.ptz) report("point_z", got.ptz, want.ptz);
      end
    end
    m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [vrt_pkg::IN_W-1:0] pack_item(input ray_item_t it);
    return vrt_pkg::IN_W'({it.dz, it.dy, it.dx, it.sz, it.sy, it.sx, it.solid, it.idx});
  endfunction

  // send one word; on acceptance update the map or queue the prediction
  task automatic send_word(input ray_item_t it, input bit lit, input logic lit_hit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= pack_item(it);
    s_user <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.cmd == vrt_pkg::CMD_WRITE) occ_map[it.idx] = it.solid;
    else if (lit) pending_rays.push_back(start_cell_res(it, lit_hit));
    else pending_rays.push_back(trace_ray(it));
  endtask

  // drain outstanding casts, then give trailing writes time to land
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rays.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [22:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    walk_limit = v;
  endtask

  function automatic ray_item_t mk_write(input int idx, input logic solid);
    ray_item_t it;
    it = '{default: '0};
    it.cmd = vrt_pkg::CMD_WRITE; it.idx = idx[14:0]; it.solid = solid;
    return it;
  endfunction

  function automatic ray_item_t mk_cast(input int sx, sy, sz, dx, dy, dz);
    ray_item_t it;
    it = '{default: '0};
    it.cmd = vrt_pkg::CMD_CAST;
    it.sx = sx[20:0]; it.sy = sy[20:0]; it.sz = sz[20:0];
    it.dx = dx[17:0]; it.dy = dy[17:0]; it.dz = dz[17:0];
    return it;
  endfunction

  function automatic ray_item_t rand_item();
    ray_item_t it;
    int lo;
    it = '{default: '0};
    if ($urandom_range(0, 99) < 35) begin
      // writes clustered in a central block so that rays hit
      if ($urandom_range(0, 4) != 0)
        it = mk_write($urandom_range(8, 23) + 32 * $urandom_range(8, 23)
                      + 1024 * $urandom_range(8, 23), $urandom_range(0, 9) < 7);
      else
        it = mk_write($urandom_range(0, 32767), $urandom_range(0, 1));
    end else begin
      it.cmd = vrt_pkg::CMD_CAST;
      if ($urandom_range(0, 99) < 85) begin
        // starts inside the grid
        it.sx = 21'($urandom_range(0, 1048575));
        it.sy = 21'($urandom_range(0, 1048575));
        it.sz = 21'($urandom_range(0, 1048575));
      end else begin
        it.sx = 21'($urandom); it.sy = 21'($urandom); it.sz = 21'($urandom);
      end
      lo = $urandom_range(0, 99);
      if (lo < 70) begin
        it.dx = 18'($urandom_range(0, 131072) - 65536);
        it.dy = 18'($urandom_range(0, 131072) - 65536);
        it.dz = 18'($urandom_range(0, 131072) - 65536);
      end else if (lo < 80) begin
        it.dx = 18'($urandom_range(0, 1) ? 0 : $urandom_range(0, 131072) - 65536);
        it.dy = 18'($urandom_range(0, 1) ? 0 : $urandom_range(0, 131072) - 65536);
        it.dz = 18'($urandom_range(0, 1) ? 0 : $urandom_range(0, 131072) - 65536);
      end else begin
        it.dx = 18'($urandom); it.dy = 18'($urandom); it.dz = 18'($urandom);
      end
    end
    return it;
  endfunction

  dir_row_t      dir_rows[$];
  logic [22:0]   phase_limits[5];

  initial begin
    dir_row_t row;
    int       n;
    walk_limit = vrt_pkg::MAX_LEN_RST;
    foreach (occ_map[i]) occ_map[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; starts in fixed point with 16 fraction bits
    row = '{default: '0};
    row.item = mk_cast(360448, 360448, 360448, 0, 0, 0); row.lit = 1; row.lit_hit = 0;
    dir_rows.push_back(row);
    row = '{default: '0}; row.item = mk_write(5285, 1); dir_rows.push_back(row);
    row.item = mk_cast(360448, 360448, 360448, 0, 0, 0); row.lit = 1; row.lit_hit = 1;
    dir_rows.push_back(row);
    row = '{default: '0};
    row.item = mk_cast(360448, 360448, 163840, 0, 0, 65536); dir_rows.push_back(row);
    row.item = mk_cast(163840, 163840, 163840, 65536, 65536, 65536); dir_rows.push_back(row);
    row.item = mk_cast(557056, 360448, 360448, -65536, 0, 0); dir_rows.push_back(row);
    row.item = mk_cast(0, 0, 0, 131071, 131071, 131071); dir_rows.push_back(row);
    row.item = mk_cast(2097151, 2097151, 2097151, -131072, -131072, -131072);
    dir_rows.push_back(row);
    row.item = mk_write(5285, 0); dir_rows.push_back(row);
    row.item = mk_cast(360448, 360448, 163840, 0, 0, 65536); dir_rows.push_back(row);
    row.item = mk_write(32767, 1); dir_rows.push_back(row);
    row.item = mk_write(0, 1); dir_rows.push_back(row);
    row.item = mk_cast(32768, 32768, 32768, 0, 0, 65536); dir_rows.push_back(row);
    row.item = mk_cast(2064384, 2064384, 2064384, -65536, 65536, -1); dir_rows.push_back(row);
    row.item = mk_cast(2031616, 2031616, 2031616, 65536, 65536, 65536); dir_rows.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.cfg_val = 0; dir_rows.push_back(row);
    row = '{default: '0};
    row.item = mk_cast(32768, 32768, 32768, 0, 0, 65536); row.lit = 1; row.lit_hit = 0;
    dir_rows.push_back(row);
    row.item = mk_cast(100000, 200000, 300000, 4000, -9000, 1); dir_rows.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.cfg_val = 23'h7FFFFF; dir_rows.push_back(row);
    row = '{default: '0};
    row.item = mk_cast(32768, 32768, 98304, 1, 0, 65536); dir_rows.push_back(row);
    row.item = mk_cast(98304, 98304, 98304, 65536, 131071, 3); dir_rows.push_back(row);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_limit(dir_rows[i].cfg_val);
      else send_word(dir_rows[i].item, dir_rows[i].lit, dir_rows[i].lit_hit);
    end

    // random phases over several walk limits
    phase_limits[0] = 23'd4194304;
    phase_limits[1] = 23'($urandom_range(1, 1000000));
    phase_limits[2] = vrt_pkg::MAX_LEN_RST;
    phase_limits[3] = 23'd65536;
    phase_limits[4] = 23'($urandom_range(100000, 4194304));
    n = RAND_ITEMS / 5;
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(phase_limits[ph]);
      send_idle_pct = (ph == 2) ? 0 : 20;
      recv_stall_pct = (ph == 2) ? 0 : 20;
      for (int k = 0; k < n; k++) begin
        if (ph == 3 && k == n / 2) wait_idle();
        send_word(rand_item(), 0, 0);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_rays.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
